/* rtl/quantized_normal_best_fit_top_macros.svh */
// Assertion macros for the checker of the normal quantiser
`ifndef QUANTIZED_NORMAL_BEST_FIT_TOP_MACROS_SVH
`define QUANTIZED_NORMAL_BEST_FIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset
`define QNBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset
`define QNBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qnbf_pkg.sv */
// Types and constants of the best-fit normal quantiser
package qnbf_pkg;

    localparam int MAX_BITS   = 16;
    localparam int N_W        = 16;
    localparam int WORD_W     = 32;
    localparam int Q_W        = 32;
    localparam int D_W        = 50;
    localparam int L_W        = 64;
    localparam int S_W        = 128;
    localparam int ACC_W      = 192;
    localparam int LIM_W      = 15;
    localparam int BITS_W     = 5;
    localparam int CNT_W      = 6;

    // Sequencer step counts
    localparam logic [CNT_W-1:0] LEN_END = 6'd4;
    localparam logic [CNT_W-1:0] DIV_MUL = 6'd0;
    localparam logic [CNT_W-1:0] DIV_LD  = 6'd1;
    localparam logic [CNT_W-1:0] DIV_END = 6'd34;
    localparam logic [CNT_W-1:0] DOT_END = 6'd7;
    localparam logic [CNT_W-1:0] SQ_END  = 6'd5;
    localparam logic [CNT_W-1:0] ML_END  = 6'd9;

    // Register indexes
    localparam logic [1:0] CFG_BIT_DEPTH    = 2'd0;
    localparam logic [1:0] CFG_REJECT_LIMIT = 2'd1;

    localparam logic [BITS_W-1:0] BIT_DEPTH_RST    = 5'd10;
    localparam logic [LIM_W-1:0]  REJECT_LIMIT_RST = 15'd18907;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LEN,
        ST_DIV,
        ST_CAND,
        ST_DOT,
        ST_CHECK,
        ST_SQ,
        ST_ML,
        ST_DECIDE,
        ST_ADV,
        ST_NEXT,
        ST_OUT
    } st_t;

endpackage

/* rtl/quantized_normal_best_fit_top.sv */
// Top level of the best-fit normal quantiser
// Usage:
//  - Input channel (in_valid/in_ready, nx/ny/nz in signed Q1.15) takes one
//    normal at a time; in_ready is high only while the sequencer is idle.
//  - Output channel (out_valid/out_ready) gives qx/qy/qz and rejected from
//    an output register; the next item is accepted while a result waits.
//  - A rejected normal or a half size of zero goes from setup to the output.
//  - Otherwise setup finds the length and runs four 32-step restoring
//    divisions, and each scale step n tries four candidates: each one
//    inside the cube gets a dot product and, where needed, an exact
//    cosine compare built from 32x32 partial products.
//  - The run time is set by the single shared 32x32 multiplier, which does
//    every product and every word of the wide cosine compare.
//  - Configuration (cfg_we, cfg_index, cfg_data) is to be written only while
//    idle, which the block does not enforce; unknown indexes are ignored.
//  - Reset clears the sequencer, the output valid and loads bit_depth 10
//    and reject_limit 18907.
//  - When out_ready is low a finished result stays in the output register
//    and the sequencer waits for it before returning to idle.
module quantized_normal_best_fit_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  nx,
    input  logic signed [15:0]  ny,
    input  logic signed [15:0]  nz,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  qx,
    output logic signed [15:0]  qy,
    output logic signed [15:0]  qz,
    output logic                rejected,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [14:0]         cfg_data
);

    qnbf_pkg::st_t st_reg, st_next;

    logic [qnbf_pkg::BITS_W-1:0] bits_reg;
    logic [qnbf_pkg::LIM_W-1:0]  limit_reg;

    logic signed [qnbf_pkg::N_W-1:0] nv_reg [3];
    logic [1:0] dom_reg, dom_in, o1, o2, kdiv;
    logic [qnbf_pkg::LIM_W-1:0] m_reg, m_next;

    logic [qnbf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] job_reg, job_next;
    logic [1:0] c_reg, c_next;
    logic side_reg, side_next;
    logic [qnbf_pkg::LIM_W-1:0] n_reg, n_next;

    logic signed [qnbf_pkg::Q_W-1:0] qa_reg [2], qa_next [2];
    logic [qnbf_pkg::LIM_W-1:0]      ra_reg [2], ra_next [2];
    logic signed [qnbf_pkg::Q_W-1:0] stp_reg [2], stp_next [2];
    logic [qnbf_pkg::LIM_W-1:0]      stb_reg [2], stb_next [2];

    logic signed [qnbf_pkg::Q_W-1:0] cq_reg [3], cq_next [3];
    logic signed [qnbf_pkg::Q_W-1:0] best_reg [3], best_next [3];
    logic signed [qnbf_pkg::D_W-1:0] d_reg, d_next, bd_reg, bd_next;
    logic [qnbf_pkg::L_W-1:0] l_reg, l_next, bl_reg, bl_next;

    logic [qnbf_pkg::ACC_W-1:0] acc_reg, acc_next, p1_reg, p1_next, shifted;
    logic [qnbf_pkg::S_W-1:0] s_reg, s_next;

    logic [qnbf_pkg::WORD_W-1:0] div_reg, div_next;
    logic [qnbf_pkg::LIM_W-1:0]  rem_reg, rem_next;

    logic [2*qnbf_pkg::WORD_W-1:0] prod_reg;
    logic [2:0] tag_reg, tag;
    logic iss_reg, iss, neg_reg, neg;
    logic [qnbf_pkg::WORD_W-1:0] mul_a, mul_b;

    logic rej_reg, rej_next;
    logic out_valid_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg;
    logic rejected_reg;

    // Working values
    logic [qnbf_pkg::BITS_W-1:0] bits_c;
    logic [15:0] pow;
    logic [qnbf_pkg::LIM_W-1:0] half;
    logic signed [qnbf_pkg::N_W-1:0] m_in;
    logic rej_c, skip, better, out_free;
    logic [qnbf_pkg::N_W-1:0] nmag [3];
    logic [qnbf_pkg::Q_W-1:0] cmag [3];
    logic signed [qnbf_pkg::D_W-1:0] xsrc, xmag;
    logic [qnbf_pkg::L_W-1:0] ysrc;
    logic [qnbf_pkg::WORD_W-1:0] xw [2], yw [2], sw [4];
    logic signed [qnbf_pkg::Q_W-1:0] cand1, cand2, half_s;
    logic [1:0] idx;
    logic [2:0] k3;
    logic [15:0] trial;
    logic ge;
    logic signed [qnbf_pkg::Q_W-1:0] qv;
    logic [qnbf_pkg::LIM_W-1:0] rv;
    logic signed [15:0] rt [2];
    logic signed [qnbf_pkg::Q_W-1:0] qt [2];

    // Clamp bit depth and derive the cube half size
    always_comb
    begin
        if (bits_reg == 5'd0)
            bits_c = 5'd1;
        else if (bits_reg > 5'(qnbf_pkg::MAX_BITS))
            bits_c = 5'(qnbf_pkg::MAX_BITS);
        else
            bits_c = bits_reg;
        pow  = 16'd1 << (bits_c - 5'd1);
        half = 15'(pow - 16'd1);
    end

    assign half_s = $signed({17'b0, half});

    // Dominant axis of the incoming normal: X over Y over Z on ties
    always_comb
    begin
        dom_in = 2'd0;
        if (ny > nx)
            dom_in = 2'd1;
        if (nz > ((dom_in == 2'd1) ? ny : nx))
            dom_in = 2'd2;
    end

    assign o1   = (dom_reg == 2'd0) ? 2'd1 : 2'd0;
    assign o2   = (dom_reg == 2'd2) ? 2'd1 : 2'd2;
    assign kdiv = job_reg[0] ? o2 : o1;
    assign m_in = nv_reg[dom_reg];
    assign rej_c = m_in <= $signed({1'b0, limit_reg});

    // Magnitudes and word views for the shared multiplier
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nmag[k] = nv_reg[k][15] ? 16'(-nv_reg[k]) : 16'(nv_reg[k]);
            cmag[k] = cq_reg[k][31] ? 32'(-cq_reg[k]) : 32'(cq_reg[k]);
        end
        xsrc  = side_reg ? bd_reg : d_reg;
        xmag  = xsrc[qnbf_pkg::D_W-1] ? -xsrc : xsrc;
        xw[0] = xmag[31:0];
        xw[1] = 32'(xmag[qnbf_pkg::D_W-1:32]);
        ysrc  = side_reg ? l_reg : bl_reg;
        yw[0] = ysrc[31:0];
        yw[1] = ysrc[63:32];
        for (int i = 0; i < 4; i++)
            sw[i] = s_reg[32*i +: 32];
    end

    // Candidate on the two minor axes
    assign cand1 = qa_reg[0] + $signed({31'b0, c_reg[0]});
    assign cand2 = qa_reg[1] + $signed({31'b0, c_reg[1]});
    assign skip  = (cand1 > half_s) || (cand2 > half_s);

    // Exact cosine ordering
    always_comb
    begin
        if (d_reg[qnbf_pkg::D_W-1] != bd_reg[qnbf_pkg::D_W-1])
            better = !d_reg[qnbf_pkg::D_W-1];
        else if (!d_reg[qnbf_pkg::D_W-1])
            better = p1_reg > acc_reg;
        else
            better = p1_reg < acc_reg;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign shifted  = qnbf_pkg::ACC_W'(prod_reg) << {tag_reg, 5'b0};

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            qnbf_pkg::ST_IDLE:
                if (in_valid)
                    st_next = qnbf_pkg::ST_SETUP;
            qnbf_pkg::ST_SETUP:
                st_next = (rej_c || half == '0) ? qnbf_pkg::ST_OUT : qnbf_pkg::ST_LEN;
            qnbf_pkg::ST_LEN:
                if (cnt_reg == qnbf_pkg::LEN_END)
                    st_next = qnbf_pkg::ST_DIV;
            qnbf_pkg::ST_DIV:
                if (cnt_reg == qnbf_pkg::DIV_END && job_reg == 2'd3)
                    st_next = qnbf_pkg::ST_CAND;
            qnbf_pkg::ST_CAND:
                st_next = skip ? qnbf_pkg::ST_ADV : qnbf_pkg::ST_DOT;
            qnbf_pkg::ST_DOT:
                if (cnt_reg == qnbf_pkg::DOT_END)
                    st_next = qnbf_pkg::ST_CHECK;
            qnbf_pkg::ST_CHECK:
                if (l_reg == '0)
                    st_next = qnbf_pkg::ST_ADV;
                else if (d_reg[qnbf_pkg::D_W-1] != bd_reg[qnbf_pkg::D_W-1])
                    st_next = qnbf_pkg::ST_DECIDE;
                else
                    st_next = qnbf_pkg::ST_SQ;
            qnbf_pkg::ST_SQ:
                if (cnt_reg == qnbf_pkg::SQ_END)
                    st_next = qnbf_pkg::ST_ML;
            qnbf_pkg::ST_ML:
                if (cnt_reg == qnbf_pkg::ML_END)
                    st_next = side_reg ? qnbf_pkg::ST_DECIDE : qnbf_pkg::ST_SQ;
            qnbf_pkg::ST_DECIDE:
                st_next = qnbf_pkg::ST_ADV;
            qnbf_pkg::ST_ADV:
                st_next = (c_reg == 2'd3) ? qnbf_pkg::ST_NEXT : qnbf_pkg::ST_CAND;
            qnbf_pkg::ST_NEXT:
                st_next = (n_reg == 15'd1) ? qnbf_pkg::ST_OUT : qnbf_pkg::ST_CAND;
            qnbf_pkg::ST_OUT:
                if (out_free)
                    st_next = qnbf_pkg::ST_IDLE;
            default:
                st_next = qnbf_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        iss   = 1'b0;
        tag   = '0;
        neg   = 1'b0;
        idx   = '0;
        k3    = '0;
        case (st_reg)
            qnbf_pkg::ST_LEN:
                if (cnt_reg inside {[1:3]})
                begin
                    idx   = 2'(cnt_reg - 6'd1);
                    mul_a = 32'(nmag[idx]);
                    mul_b = 32'(nmag[idx]);
                    iss   = 1'b1;
                end
            qnbf_pkg::ST_DIV:
                if (cnt_reg == qnbf_pkg::DIV_MUL)
                begin
                    mul_a = 32'(half);
                    mul_b = 32'(nmag[kdiv]);
                end
            qnbf_pkg::ST_DOT:
                if (cnt_reg inside {[1:6]})
                begin
                    k3  = 3'(cnt_reg - 6'd1);
                    tag = k3;
                    iss = 1'b1;
                    if (k3 < 3'd3)
                    begin
                        idx   = k3[1:0];
                        mul_a = cmag[idx];
                        mul_b = 32'(nmag[idx]);
                        neg   = cq_reg[idx][31] ^ nv_reg[idx][15];
                    end
                    else
                    begin
                        idx   = 2'(k3 - 3'd3);
                        mul_a = cmag[idx];
                        mul_b = cmag[idx];
                    end
                end
            qnbf_pkg::ST_SQ:
                if (cnt_reg inside {[1:4]})
                begin
                    idx   = 2'(cnt_reg - 6'd1);
                    mul_a = xw[idx[0]];
                    mul_b = xw[idx[1]];
                    tag   = 3'(idx[0]) + 3'(idx[1]);
                    iss   = 1'b1;
                end
            qnbf_pkg::ST_ML:
                if (cnt_reg inside {[1:8]})
                begin
                    k3    = 3'(cnt_reg - 6'd1);
                    mul_a = sw[k3[1:0]];
                    mul_b = yw[k3[2]];
                    tag   = 3'(k3[1:0]) + 3'(k3[2]);
                    iss   = 1'b1;
                end
            default:
                mul_a = '0;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        m_next    = m_reg;
        job_next  = job_reg;
        c_next    = c_reg;
        side_next = side_reg;
        n_next    = n_reg;
        qa_next   = qa_reg;
        ra_next   = ra_reg;
        stp_next  = stp_reg;
        stb_next  = stb_reg;
        cq_next   = cq_reg;
        best_next = best_reg;
        d_next    = d_reg;
        l_next    = l_reg;
        bd_next   = bd_reg;
        bl_next   = bl_reg;
        acc_next  = acc_reg;
        p1_next   = p1_reg;
        s_next    = s_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        rej_next  = rej_reg;
        trial     = {rem_reg, div_reg[31]};
        ge        = trial >= {1'b0, m_reg};
        qv        = '0;
        rv        = '0;
        for (int i = 0; i < 2; i++)
        begin
            rt[i] = $signed({1'b0, ra_reg[i]}) - $signed({1'b0, stb_reg[i]});
            qt[i] = qa_reg[i] - stp_reg[i];
        end
        cnt_next = (st_next != st_reg) ? '0 : cnt_reg + 6'd1;

        case (st_reg)
            qnbf_pkg::ST_SETUP:
            begin
                m_next   = m_in[14:0];
                rej_next = rej_c;
                job_next = '0;
                for (int k = 0; k < 3; k++)
                    best_next[k] = '0;
            end
            qnbf_pkg::ST_LEN:
                if (cnt_reg == '0)
                    bl_next = '0;
                else if (iss_reg)
                    bl_next = bl_reg + prod_reg;
            qnbf_pkg::ST_DIV:
            begin
                // Floor-divide one numerator by the dominant component
                if (cnt_reg == qnbf_pkg::DIV_MUL)
                    bd_next = -$signed(bl_reg[qnbf_pkg::D_W-1:0]);
                else if (cnt_reg == qnbf_pkg::DIV_LD)
                begin
                    div_next = job_reg[1] ? prod_reg[31:0] : 32'(nmag[kdiv]);
                    rem_next = '0;
                end
                else if (cnt_reg != qnbf_pkg::DIV_END)
                begin
                    rem_next = ge ? 15'(trial - {1'b0, m_reg}) : trial[14:0];
                    div_next = {div_reg[30:0], ge};
                end
                else
                begin
                    if (nv_reg[kdiv][15])
                    begin
                        qv = (rem_reg != '0) ? -($signed(div_reg) + 32'sd1)
                                             : -$signed(div_reg);
                        rv = (rem_reg != '0) ? 15'(m_reg - rem_reg) : '0;
                    end
                    else
                    begin
                        qv = $signed(div_reg);
                        rv = rem_reg;
                    end
                    if (job_reg[1])
                    begin
                        qa_next[job_reg[0]] = qv;
                        ra_next[job_reg[0]] = rv;
                    end
                    else
                    begin
                        stp_next[job_reg[0]] = qv;
                        stb_next[job_reg[0]] = rv;
                    end
                    job_next = job_reg + 2'd1;
                    if (job_reg != 2'd3)
                        cnt_next = '0;
                    n_next = half;
                    c_next = '0;
                end
            end
            qnbf_pkg::ST_CAND:
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) == dom_reg)
                        cq_next[k] = $signed({17'b0, n_reg});
                    else if (2'(k) == o1)
                        cq_next[k] = cand1;
                    else
                        cq_next[k] = cand2;
                end
            qnbf_pkg::ST_DOT:
                if (cnt_reg == '0)
                begin
                    d_next = '0;
                    l_next = '0;
                end
                else if (iss_reg)
                begin
                    if (tag_reg < 3'd3)
                        d_next = neg_reg ? d_reg - $signed(qnbf_pkg::D_W'(prod_reg))
                                         : d_reg + $signed(qnbf_pkg::D_W'(prod_reg));
                    else
                        l_next = l_reg + prod_reg;
                end
            qnbf_pkg::ST_CHECK:
                side_next = 1'b0;
            qnbf_pkg::ST_SQ:
                if (cnt_reg == '0)
                begin
                    if (side_reg)
                        p1_next = acc_reg;
                    acc_next = '0;
                end
                else if (iss_reg)
                    acc_next = acc_reg + shifted;
            qnbf_pkg::ST_ML:
            begin
                if (cnt_reg == '0)
                begin
                    s_next   = acc_reg[qnbf_pkg::S_W-1:0];
                    acc_next = '0;
                end
                else if (iss_reg)
                    acc_next = acc_reg + shifted;
                if (cnt_reg == qnbf_pkg::ML_END)
                    side_next = 1'b1;
            end
            qnbf_pkg::ST_DECIDE:
                if (better)
                begin
                    bd_next   = d_reg;
                    bl_next   = l_reg;
                    best_next = cq_reg;
                end
            qnbf_pkg::ST_ADV:
                c_next = c_reg + 2'd1;
            qnbf_pkg::ST_NEXT:
            begin
                // Step the floor quotients down by one multiple of the normal
                n_next = n_reg - 15'd1;
                c_next = '0;
                for (int i = 0; i < 2; i++)
                begin
                    if (rt[i] < 0)
                    begin
                        ra_next[i] = 15'(rt[i] + $signed({1'b0, m_reg}));
                        qa_next[i] = qt[i] - 32'sd1;
                    end
                    else
                    begin
                        ra_next[i] = rt[i][14:0];
                        qa_next[i] = qt[i];
                    end
                end
            end
            default:
                m_next = m_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= qnbf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            iss_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            bits_reg      <= qnbf_pkg::BIT_DEPTH_RST;
            limit_reg     <= qnbf_pkg::REJECT_LIMIT_RST;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            iss_reg <= iss;
            if (st_reg == qnbf_pkg::ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    qnbf_pkg::CFG_BIT_DEPTH:    bits_reg  <= cfg_data[4:0];
                    qnbf_pkg::CFG_REJECT_LIMIT: limit_reg <= cfg_data;
                    default:                    bits_reg  <= bits_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (st_reg == qnbf_pkg::ST_IDLE && in_valid)
        begin
            nv_reg[0] <= nx;
            nv_reg[1] <= ny;
            nv_reg[2] <= nz;
            dom_reg   <= dom_in;
        end
        prod_reg  <= 64'(mul_a) * 64'(mul_b);
        tag_reg   <= tag;
        neg_reg   <= neg;
        m_reg     <= m_next;
        job_reg   <= job_next;
        c_reg     <= c_next;
        side_reg  <= side_next;
        n_reg     <= n_next;
        qa_reg    <= qa_next;
        ra_reg    <= ra_next;
        stp_reg   <= stp_next;
        stb_reg   <= stb_next;
        cq_reg    <= cq_next;
        best_reg  <= best_next;
        d_reg     <= d_next;
        l_reg     <= l_next;
        bd_reg    <= bd_next;
        bl_reg    <= bl_next;
        acc_reg   <= acc_next;
        p1_reg    <= p1_next;
        s_reg     <= s_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        rej_reg   <= rej_next;
        if (st_reg == qnbf_pkg::ST_OUT && out_free)
        begin
            qx_reg       <= best_reg[0][15:0];
            qy_reg       <= best_reg[1][15:0];
            qz_reg       <= best_reg[2][15:0];
            rejected_reg <= rej_reg;
        end
    end

    // Drive the ports
    assign in_ready  = (st_reg == qnbf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
    assign qz        = qz_reg;
    assign rejected  = rejected_reg;

endmodule

/* rtl/qnbf_checker.sv */
// Port-level checks of the normal quantiser, bound to the top level
`include "quantized_normal_best_fit_top_macros.svh"

module qnbf_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] qx,
    input logic signed [15:0] qy,
    input logic signed [15:0] qz,
    input logic               rejected
);

    // Hold a stalled result
    `QNBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(qx) && $stable(qy) && $stable(qz) && $stable(rejected), "stalled result changed")

    // A rejected normal gives the zero vector
    `QNBF_ASSERT_IMP(a_rej_zero, out_valid && rejected, qx == 16'sd0 && qy == 16'sd0 && qz == 16'sd0, "rejected result not zero")

    // Drop ready once an item is taken
    `QNBF_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "ready held after accept")

    // No result appears in the cycle after an item is taken
    `QNBF_ASSERT_NXT(a_no_early, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind quantized_normal_best_fit_top qnbf_checker u_qnbf_checker (.*);
